// ----- rtl/flat_json_object_tokenizer_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the flat JSON object tokenizer
// Clocked on clk_i; FJT_ASSERT is disabled during reset, FJT_ASSERT_RST is not.
// ----------------------------------------------------------------------------
`ifndef FLAT_JSON_OBJECT_TOKENIZER_DEFINES_SVH
`define FLAT_JSON_OBJECT_TOKENIZER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define FJT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("fjt assertion failed");
`define FJT_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("fjt reset assertion failed");
`else
`define FJT_ASSERT(lbl, prop)
`define FJT_ASSERT_RST(lbl, prop)
`endif

`endif

// ----- rtl/fjt_pkg.sv -----
// ----------------------------------------------------------------------------
// fjt_pkg
// Result kinds, character codes and the per-byte result bundle.
// ----------------------------------------------------------------------------
package fjt_pkg;

  typedef enum logic [2:0] {
    KIND_KEY_BYTE = 3'd0,
    KIND_VAL_BYTE = 3'd1,
    KIND_KEY_END  = 3'd2,
    KIND_VAL_END  = 3'd3,
    KIND_ACCEPT   = 3'd4,
    KIND_REJECT   = 3'd5
  } item_kind_e;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
  } entry_t;

  // results caused by one input byte; count is 1..3 when pushed
  typedef struct packed {
    logic [1:0]                  count;
    entry_t [MaxResults-1:0]     ent;
  } bundle_t;

endpackage

// ----- rtl/flat_json_object_tokenizer.sv -----
// ----------------------------------------------------------------------------
// flat_json_object_tokenizer
// Checks a flat object of quoted string pairs and streams its tokens.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o): one text byte per item, with
// end_of_text_i marking the last byte of a text; the parser restarts after it.
// Output channel (out_valid_o/out_ready_i): one token per item - key byte,
// value byte, key end, value end, accepted or rejected - with last_of_run_o
// set on the final token caused by an input byte. Bytes yielding no token
// (opening braces, colons, whitespace, opening quotes, bytes after a verdict)
// produce nothing on the output.
// A byte's tokens pass through the bundle queue, then the output register.
// Throughput: one byte per cycle while each byte yields at most one token; a
// byte yielding several tokens fills the output register one token at a time,
// and the bundle queue (QueueDepth entries) absorbs the difference.
// When the receiver stalls, tokens wait in the output register and the
// queue; input is stalled only once the queue is full.
// Reset clears parser state, queue and output valid; no tokens are pending.
// ----------------------------------------------------------------------------
module flat_json_object_tokenizer import fjt_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] item_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic    q_full;
  logic    push;
  logic    pop;
  logic    head_valid;
  bundle_t push_bundle;
  bundle_t head;

  fjt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .bundle_o      (push_bundle)
  );

  fjt_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .bundle_i     (push_bundle),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  fjt_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .item_kind_o   (item_kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

// ----- rtl/fjt_front.sv -----
// ----------------------------------------------------------------------------
// fjt_front
// Parser state machine: classifies each byte and builds its result bundle.
// ----------------------------------------------------------------------------
`include "flat_json_object_tokenizer_defines.svh"

module fjt_front import fjt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_text_i,
  input  logic       q_full_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  localparam logic [3:0] PH_WAIT_OPEN   = 4'd0;
  localparam logic [3:0] PH_AFTER_OPEN  = 4'd1;
  localparam logic [3:0] PH_KEY_FIRST   = 4'd2;
  localparam logic [3:0] PH_KEY         = 4'd3;
  localparam logic [3:0] PH_AFTER_KEY   = 4'd4;
  localparam logic [3:0] PH_AFTER_COLON = 4'd5;
  localparam logic [3:0] PH_VALUE       = 4'd6;
  localparam logic [3:0] PH_AFTER_VALUE = 4'd7;
  localparam logic [3:0] PH_DONE        = 4'd8;

  logic [3:0] phase_q, phase_d;
  logic       held_q, held_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    logic [1:0] n;
    logic       is_sp;
    logic       in_str;
    item_kind_e kbyte;
    item_kind_e kend;
    logic [3:0] nxt;
    n        = 2'd0;
    is_sp    = (in_byte_i == CH_SPACE) || (in_byte_i == CH_NL);
    in_str   = 1'b0;
    phase_d  = phase_q;
    held_d   = held_q;
    bundle_o = '0;
    if (phase_q == PH_VALUE) begin
      kbyte = KIND_VAL_BYTE;
      kend  = KIND_VAL_END;
      nxt   = PH_AFTER_VALUE;
    end else begin
      kbyte = KIND_KEY_BYTE;
      kend  = KIND_KEY_END;
      nxt   = PH_AFTER_KEY;
    end

    unique case (phase_q)
      PH_WAIT_OPEN: begin
        if (in_byte_i == CH_LBRACE) phase_d = PH_AFTER_OPEN;
        else phase_d = PH_DONE;
      end
      PH_AFTER_OPEN: begin
        if (in_byte_i == CH_QUOTE) phase_d = PH_KEY_FIRST;
        else if (!is_sp) phase_d = PH_DONE;
      end
      PH_KEY_FIRST: begin
        if (in_byte_i == CH_QUOTE) phase_d = PH_DONE;  // empty key
        else begin
          phase_d = PH_KEY;
          in_str  = 1'b1;
        end
      end
      PH_KEY, PH_VALUE: in_str = 1'b1;
      PH_AFTER_KEY: begin
        if (in_byte_i == CH_COLON) phase_d = PH_AFTER_COLON;
        else if (!is_sp) phase_d = PH_DONE;
      end
      PH_AFTER_COLON: begin
        if (in_byte_i == CH_QUOTE) begin
          phase_d = PH_VALUE;
          held_d  = 1'b0;
        end else if (!is_sp) begin
          phase_d = PH_DONE;
        end
      end
      PH_AFTER_VALUE: begin
        if (in_byte_i == CH_COMMA) phase_d = PH_AFTER_OPEN;
        else if (in_byte_i == CH_RBRACE) begin
          bundle_o.ent[n].kind = KIND_ACCEPT;
          n       = n + 2'd1;
          phase_d = PH_DONE;
          held_d  = 1'b0;
        end else if (!is_sp) phase_d = PH_DONE;
      end
      default: ;
    endcase

    // a rejection from the phase logic lands in PH_DONE without a result yet
    if (phase_d == PH_DONE && phase_q != PH_DONE && n == 2'd0) begin
      bundle_o.ent[n].kind = KIND_REJECT;
      n      = n + 2'd1;
      held_d = 1'b0;
    end

    if (in_str) begin
      if (in_byte_i == CH_QUOTE) begin
        if (held_q) begin
          bundle_o.ent[n].kind = kbyte;
          bundle_o.ent[n].data = CH_QUOTE;
          n      = n + 2'd1;
          held_d = 1'b0;
        end else begin
          bundle_o.ent[n].kind = kend;
          n       = n + 2'd1;
          phase_d = nxt;
        end
      end else if (in_byte_i == CH_BSLASH) begin
        if (held_q) begin
          bundle_o.ent[n].kind = kbyte;
          bundle_o.ent[n].data = CH_BSLASH;
          n = n + 2'd1;
        end
        held_d = 1'b1;
      end else begin
        if (held_q) begin
          bundle_o.ent[n].kind = kbyte;
          bundle_o.ent[n].data = CH_BSLASH;
          n = n + 2'd1;
        end
        held_d = 1'b0;
        bundle_o.ent[n].kind = kbyte;
        bundle_o.ent[n].data = in_byte_i;
        n = n + 2'd1;
      end
    end

    if (end_of_text_i) begin
      if (phase_d < PH_DONE) begin
        bundle_o.ent[n].kind = KIND_REJECT;
        n = n + 2'd1;
      end
      phase_d = PH_WAIT_OPEN;
      held_d  = 1'b0;
    end

    bundle_o.count = n;
  end

  assign push_o = accept && (bundle_o.count != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_OPEN;
      held_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // a pending backslash only exists inside a key or value
  `FJT_ASSERT(a_held_in_string, held_q |-> (phase_q == PH_KEY || phase_q == PH_VALUE))
  // end of text always returns the parser to its start
  `FJT_ASSERT(a_eot_restart, (accept && end_of_text_i) |=> (phase_q == PH_WAIT_OPEN && !held_q))

endmodule

// ----- rtl/fjt_queue.sv -----
// ----------------------------------------------------------------------------
// fjt_queue
// Small register FIFO of result bundles between parser and output stage.
// ----------------------------------------------------------------------------
`include "flat_json_object_tokenizer_defines.svh"

module fjt_queue import fjt_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  input  logic    pop_i,
  output logic    full_o,
  output logic    head_valid_o,
  output bundle_t head_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);
  localparam logic [PW-1:0] LastPtr = PW'(Depth - 1);
  localparam logic [CW-1:0] DepthC  = CW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   cnt_q, cnt_d;

  assign full_o       = (cnt_q == DepthC);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= bundle_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      cnt_q <= cnt_d;
    end
  end

  `FJT_ASSERT(a_no_push_full, push_i |-> !full_o)
  `FJT_ASSERT(a_no_pop_empty, pop_i |-> head_valid_o)
  // count is unknown until reset is first applied
  `FJT_ASSERT_RST(a_cnt_range, !rst_ni || (cnt_q <= DepthC))

endmodule

// ----- rtl/fjt_back.sv -----
// ----------------------------------------------------------------------------
// fjt_back
// Unpacks each bundle into single result items through an output register.
// ----------------------------------------------------------------------------
`include "flat_json_object_tokenizer_defines.svh"

module fjt_back import fjt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  bundle_t    head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] item_kind_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic [1:0] idx_q, idx_d;
  logic       valid_q;
  item_kind_e kind_q;
  logic [7:0] data_q;
  logic       last_q;
  logic       load;
  logic       is_last;
  entry_t     cur;

  assign load    = head_valid_i && (!valid_q || out_ready_i);
  assign cur     = head_i.ent[idx_q];
  assign is_last = (idx_q == head_i.count - 2'd1);
  assign pop_o   = load && is_last;
  assign idx_d   = is_last ? 2'd0 : idx_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= idx_d;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= cur.kind;
      data_q <= cur.data;
      last_q <= is_last;
    end
  end

  assign out_valid_o   = valid_q;
  assign item_kind_o   = kind_q;
  assign out_byte_o    = data_q;
  assign last_of_run_o = last_q;

  // mid-bundle index never outruns the bundle's count
  `FJT_ASSERT(a_idx_in_bundle, head_valid_i |-> (idx_q < head_i.count))
  `FJT_ASSERT(a_idx_idle_zero, !head_valid_i |-> (idx_q == 2'd0))

endmodule

// ----- bench/tb_flat_json_object_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tb_flat_json_object_tokenizer
// Streams short texts through the tokenizer, well-formed objects with random
// keys, values, escapes and whitespace, plus corrupted, truncated and noise
// texts. A token scoreboard predicts every token per accepted byte and checks
// the output stream in order, with bursty input and a shifting output stall.
// ----------------------------------------------------------------------------
module tb_flat_json_object_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import fjt_pkg::*;

  localparam int unsigned RandomItems = 330;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned SettleTicks = 8;

  typedef enum logic [3:0] {
    ST_EXPECT_BRACE,
    ST_EXPECT_KEY,
    ST_KEY_START,
    ST_KEY,
    ST_EXPECT_COLON,
    ST_EXPECT_VALUE,
    ST_VALUE,
    ST_EXPECT_SEP,
    ST_VERDICT
  } parse_state_e;

  typedef struct packed {
    item_kind_e kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  class token_scoreboard;
    parse_state_e state;
    logic         held_bs;
    token_t       expected_q[$];
    int unsigned  failures;
    int unsigned  live_bytes;

    function new();
      state      = ST_EXPECT_BRACE;
      held_bs    = 1'b0;
      failures   = 0;
      live_bytes = 0;
    endfunction

    function void emit(item_kind_e kind, logic [7:0] data);
      token_t t;
      t.kind = kind;
      t.data = data;
      t.last = 1'b0;
      expected_q.push_back(t);
    endfunction

    function void give_verdict(item_kind_e kind);
      emit(kind, 8'h00);
      state   = ST_VERDICT;
      held_bs = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c == CH_SPACE || c == CH_NL;
    endfunction

    // a backslash is held back until the next byte shows whether it escapes a quote
    function void string_char(logic [7:0] c, bit in_value);
      item_kind_e byte_kind;
      byte_kind = in_value ? KIND_VAL_BYTE : KIND_KEY_BYTE;
      if (c == CH_QUOTE) begin
        if (held_bs) begin
          emit(byte_kind, CH_QUOTE);
          held_bs = 1'b0;
        end else begin
          emit(in_value ? KIND_VAL_END : KIND_KEY_END, 8'h00);
          state = in_value ? ST_EXPECT_SEP : ST_EXPECT_COLON;
        end
      end else if (c == CH_BSLASH) begin
        if (held_bs) emit(byte_kind, CH_BSLASH);
        held_bs = 1'b1;
      end else begin
        if (held_bs) emit(byte_kind, CH_BSLASH);
        held_bs = 1'b0;
        emit(byte_kind, c);
      end
    endfunction

    // accepted input item: predict its tokens
    function void note_byte(logic [7:0] c, logic eot);
      int unsigned first;
      token_t      t;
      first = expected_q.size();
      if (state != ST_VERDICT) live_bytes++;
      case (state)
        ST_EXPECT_BRACE: begin
          if (c == CH_LBRACE) state = ST_EXPECT_KEY;
          else give_verdict(KIND_REJECT);
        end
        ST_EXPECT_KEY: begin
          if (c == CH_QUOTE) state = ST_KEY_START;
          else if (!is_blank(c)) give_verdict(KIND_REJECT);
        end
        ST_KEY_START: begin
          if (c == CH_QUOTE) begin
            give_verdict(KIND_REJECT);
          end else begin
            state = ST_KEY;
            string_char(c, 1'b0);
          end
        end
        ST_KEY: string_char(c, 1'b0);
        ST_EXPECT_COLON: begin
          if (c == CH_COLON) state = ST_EXPECT_VALUE;
          else if (!is_blank(c)) give_verdict(KIND_REJECT);
        end
        ST_EXPECT_VALUE: begin
          if (c == CH_QUOTE) begin
            state   = ST_VALUE;
            held_bs = 1'b0;
          end else if (!is_blank(c)) begin
            give_verdict(KIND_REJECT);
          end
        end
        ST_VALUE: string_char(c, 1'b1);
        ST_EXPECT_SEP: begin
          if (c == CH_COMMA) state = ST_EXPECT_KEY;
          else if (c == CH_RBRACE) give_verdict(KIND_ACCEPT);
          else if (!is_blank(c)) give_verdict(KIND_REJECT);
        end
        default: ;
      endcase
      if (eot) begin
        if (state != ST_VERDICT) emit(KIND_REJECT, 8'h00);
        state   = ST_EXPECT_BRACE;
        held_bs = 1'b0;
      end
      if (expected_q.size() > first) begin
        t = expected_q.pop_back();
        t.last = 1'b1;
        expected_q.push_back(t);
      end
    endfunction

    // accepted output item: compare with the oldest prediction
    function void check_token(logic [2:0] kind, logic [7:0] data, logic last);
      token_t want;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected token: kind %0d byte %02h last %0b", kind, data, last);
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind || data !== want.data || last !== want.last) begin
        failures++;
        if (failures <= 10)
          $display("token mismatch: got kind %0d byte %02h last %0b, want kind %0d byte %02h last %0b",
                   kind, data, last, want.kind, want.data, want.last);
      end
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i     = 8'h00;
  logic       end_of_text_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i   = 1'b0;
  logic [2:0] item_kind_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;

  token_scoreboard sb;
  logic [7:0]      text_q[$];
  int unsigned     burst_left = 0;
  int unsigned     gap;
  int unsigned     cycle_count = 0;

  flat_json_object_tokenizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .end_of_text_i (end_of_text_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .item_kind_o   (item_kind_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && sb != null) begin
      if (in_valid_i && in_ready_o) sb.note_byte(in_byte_i, end_of_text_i);
      if (out_valid_o && out_ready_i) sb.check_token(item_kind_o, out_byte_o, last_of_run_o);
    end
  end

  // receiver: free-running, coin-flip, mostly stalled, then a fixed pattern
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    case (cycle_count[9:8])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= ($urandom_range(0, 1) == 0);
      2'd2:    out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (cycle_count[2:0] < 3'd3);
    endcase
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // structural characters turn up far more often than a flat random byte allows
  function automatic logic [7:0] noise_char();
    logic [7:0] marks[8];
    marks = '{CH_LBRACE, CH_RBRACE, CH_QUOTE, CH_COLON, CH_COMMA, CH_SPACE, CH_NL, CH_BSLASH};
    if ($urandom_range(0, 1) == 0) return marks[$urandom_range(0, 7)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
    return c;
  endfunction

  task automatic add_blank();
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
      text_q.push_back($urandom_range(0, 1) ? CH_SPACE : CH_NL);
  endtask

  // never ends on a lone backslash, so the closing quote always closes
  task automatic add_string(input int unsigned min_elems);
    int unsigned n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(min_elems, 3);
    text_q.push_back(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_QUOTE);
        end
        1: begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(plain_char());
        end
        2: begin
          text_q.push_back(CH_BSLASH);
          text_q.push_back(CH_BSLASH);
          text_q.push_back(plain_char());
        end
        default: text_q.push_back(plain_char());
      endcase
    end
    text_q.push_back(CH_QUOTE);
  endtask

  task automatic build_text();
    int unsigned pick;
    int unsigned pairs;
    int unsigned i;
    text_q.delete();
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      if ($urandom_range(0, 1) == 0) text_q.push_back(CH_LBRACE);
      repeat ($urandom_range(1, 6)) text_q.push_back(noise_char());
    end else begin
      pairs = $urandom_range(1, 4);
      text_q.push_back(CH_LBRACE);
      for (i = 0; i < pairs; i++) begin
        if (i > 0) text_q.push_back(CH_COMMA);
        add_blank();
        add_string(1);
        add_blank();
        text_q.push_back(CH_COLON);
        add_blank();
        add_string(0);
        add_blank();
      end
      text_q.push_back(CH_RBRACE);
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(noise_char());
      if (pick == 2) text_q[$urandom_range(0, text_q.size() - 1)] = noise_char();
      else if (pick == 3) text_q = text_q[0:$urandom_range(0, text_q.size() - 2)];
    end
  endtask

  // end of text rides on the last byte; gaps fall between bursts
  task automatic send_text();
    foreach (text_q[i]) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      burst_left--;
      in_valid_i    <= 1'b1;
      in_byte_i     <= text_q[i];
      end_of_text_i <= (i == text_q.size() - 1);
      do @(posedge clk_i); while (!in_ready_o);
    end
  endtask

  initial begin
    int unsigned base;
    int unsigned waited;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // escaped quote, double backslash, byte extremes in a value, junk after accept
    text_q = '{CH_LBRACE, CH_QUOTE, CH_BSLASH, CH_QUOTE, CH_BSLASH, CH_BSLASH, "b", CH_QUOTE,
               CH_COLON, CH_QUOTE, 8'h00, 8'hFF, CH_QUOTE, CH_RBRACE, "x"};
    send_text();
    // leading whitespace
    text_q = '{CH_SPACE};
    send_text();
    // empty key, then an ignored byte
    text_q = '{CH_LBRACE, CH_QUOTE, CH_QUOTE, "z"};
    send_text();
    // empty object
    text_q = '{CH_LBRACE, CH_RBRACE};
    send_text();
    // empty value followed by a trailing comma
    text_q = '{CH_LBRACE, CH_QUOTE, "k", CH_QUOTE, CH_COLON, CH_QUOTE, CH_QUOTE, CH_COMMA,
               CH_RBRACE};
    send_text();
    // held backslash flushed by the final byte of an open object: three tokens
    text_q = '{CH_LBRACE, CH_QUOTE, CH_BSLASH, "x"};
    send_text();

    base = sb.live_bytes;
    while (sb.live_bytes < base + RandomItems) begin
      build_text();
      send_text();
    end
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.expected_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleTicks) @(posedge clk_i);
    if (sb.expected_q.size() != 0) begin
      $display("%0d predicted tokens never arrived", sb.expected_q.size());
      sb.failures++;
    end
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/fjt_pkg.sv
rtl/fjt_front.sv
rtl/fjt_queue.sv
rtl/fjt_back.sv
rtl/flat_json_object_tokenizer.sv
bench/tb_flat_json_object_tokenizer.sv
